// ===== design/rpc_pkg.sv =====
// rpc_pkg: shared constants, arctangent table and control struct for the
// rectangular/polar converter. No dependencies.
package rpc_pkg;

  // guard bits below the operand lsb in the cordic data path
  localparam int unsigned GUARD_BITS = 16;
  // angle path width: 32-bit binary angle plus headroom for the residual
  localparam int unsigned ZW = 34;
  localparam int unsigned ANG_W = 32;

  // converged cordic gain, q30
  localparam int unsigned GAIN_W = 30;
  localparam logic [GAIN_W-1:0] GAIN_K = 30'd652032874;
  // split of the gain product into high and low partial products
  localparam int unsigned GAIN_LO_BITS = 20;
  localparam int unsigned GAIN_RND_BIT = 25;
  localparam int unsigned GAIN_SHIFT = 26;

  // half a turn in binary angle units
  localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [0:31][ANG_W-1:0] ATAN_TABLE = {
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // conversion direction
  typedef enum logic {
    CMD_TO_POLAR = 1'b0,
    CMD_TO_RECT  = 1'b1
  } cmd_e;

  // control travelling alongside each vector
  typedef struct packed {
    cmd_e cmd;
    logic zero;  // zero vector, angle forced to 0
  } ctrl_t;

endpackage

// ===== design/rpc_prep.sv =====
// rpc_prep: input set-up stage, scales the operands and folds the vector or
// angle into the right half plane. Depends on rpc_pkg.
module rpc_prep #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  rpc_pkg::cmd_e                           cmd_i,
  input  logic signed [DATA_WIDTH-1:0]            a_i,
  input  logic signed [DATA_WIDTH-1:0]            b_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output rpc_pkg::ctrl_t                          ctrl_o,
  output logic signed [DATA_WIDTH+rpc_pkg::GUARD_BITS+2:0] x_o,
  output logic signed [DATA_WIDTH+rpc_pkg::GUARD_BITS+2:0] y_o,
  output logic signed [rpc_pkg::ZW-1:0]           z_o
);

  localparam int unsigned W = DATA_WIDTH + rpc_pkg::GUARD_BITS + 3;

  logic                      valid_q;
  rpc_pkg::ctrl_t            ctrl_d, ctrl_q;
  logic signed [W-1:0]       x_d, y_d, x_q, y_q;
  logic signed [rpc_pkg::ZW-1:0] z_d, z_q;

  logic signed [DATA_WIDTH:0] a_ext, b_ext, a_neg, b_neg, xa, yb;
  logic [rpc_pkg::ANG_W-1:0] z_ang, z_fold;
  logic                      flip;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    a_ext = {a_i[DATA_WIDTH-1], a_i};
    b_ext = {b_i[DATA_WIDTH-1], b_i};
    a_neg = -a_ext;
    b_neg = -b_ext;
    // binary angle moved to the top of a 32-bit turn
    z_ang = rpc_pkg::ANG_W'({{(rpc_pkg::ANG_W-DATA_WIDTH){1'b0}}, b_i})
            << (rpc_pkg::ANG_W - DATA_WIDTH);
    flip   = z_ang[rpc_pkg::ANG_W-1] ^ z_ang[rpc_pkg::ANG_W-2];
    z_fold = flip ? (z_ang ^ rpc_pkg::HALF_TURN) : z_ang;

    ctrl_d.cmd  = cmd_i;
    ctrl_d.zero = 1'b0;
    z_d = '0;
    case (cmd_i)
      rpc_pkg::CMD_TO_POLAR: begin
        ctrl_d.zero = (a_i == '0) && (b_i == '0);
        xa = a_i[DATA_WIDTH-1] ? a_neg : a_ext;
        yb = a_i[DATA_WIDTH-1] ? b_neg : b_ext;
        if (a_i[DATA_WIDTH-1]) begin
          z_d = rpc_pkg::ZW'(rpc_pkg::HALF_TURN);
        end
      end
      rpc_pkg::CMD_TO_RECT: begin
        xa  = flip ? a_neg : a_ext;
        yb  = '0;
        z_d = {{(rpc_pkg::ZW-rpc_pkg::ANG_W){z_fold[rpc_pkg::ANG_W-1]}}, z_fold};
      end
      default: begin
        xa = '0;
        yb = '0;
      end
    endcase
    x_d = {{(W-DATA_WIDTH-1-rpc_pkg::GUARD_BITS){xa[DATA_WIDTH]}}, xa,
           {rpc_pkg::GUARD_BITS{1'b0}}};
    y_d = {{(W-DATA_WIDTH-1-rpc_pkg::GUARD_BITS){yb[DATA_WIDTH]}}, yb,
           {rpc_pkg::GUARD_BITS{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctrl_q <= ctrl_d;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

// ===== design/rpc_cordic_cell.sv =====
// rpc_cordic_cell: one cordic micro-rotation with its pipeline register.
// Depends on rpc_pkg.
module rpc_cordic_cell #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned STAGE      = 0
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  rpc_pkg::ctrl_t                          ctrl_i,
  input  logic signed [DATA_WIDTH+rpc_pkg::GUARD_BITS+2:0] x_i,
  input  logic signed [DATA_WIDTH+rpc_pkg::GUARD_BITS+2:0] y_i,
  input  logic signed [rpc_pkg::ZW-1:0]           z_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output rpc_pkg::ctrl_t                          ctrl_o,
  output logic signed [DATA_WIDTH+rpc_pkg::GUARD_BITS+2:0] x_o,
  output logic signed [DATA_WIDTH+rpc_pkg::GUARD_BITS+2:0] y_o,
  output logic signed [rpc_pkg::ZW-1:0]           z_o
);

  localparam int unsigned W = DATA_WIDTH + rpc_pkg::GUARD_BITS + 3;
  localparam logic signed [rpc_pkg::ZW-1:0] ATAN_STEP =
    rpc_pkg::ZW'(rpc_pkg::ATAN_TABLE[STAGE]);

  logic                          valid_q;
  rpc_pkg::ctrl_t                ctrl_q;
  logic signed [W-1:0]           x_d, y_d, x_q, y_q, x_sh, y_sh;
  logic signed [rpc_pkg::ZW-1:0] z_d, z_q;
  logic                          ccw;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    x_sh = x_i >>> STAGE;
    y_sh = y_i >>> STAGE;
    // to polar drives y to zero, to rect drives the residual angle to zero
    ccw = (ctrl_i.cmd == rpc_pkg::CMD_TO_RECT) ? !z_i[rpc_pkg::ZW-1] : y_i[W-1];
    if (ccw) begin
      x_d = x_i - y_sh;
      y_d = y_i + x_sh;
      z_d = z_i - ATAN_STEP;
    end else begin
      x_d = x_i + y_sh;
      y_d = y_i - x_sh;
      z_d = z_i + ATAN_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctrl_q <= ctrl_i;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

// ===== design/rpc_post.sv =====
// rpc_post: gain correction, angle rounding and saturation, four register
// stages with the last one as the output register. Depends on rpc_pkg.
module rpc_post #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  rpc_pkg::ctrl_t                          ctrl_i,
  input  logic signed [DATA_WIDTH+rpc_pkg::GUARD_BITS+2:0] x_i,
  input  logic signed [DATA_WIDTH+rpc_pkg::GUARD_BITS+2:0] y_i,
  input  logic signed [rpc_pkg::ZW-1:0]           z_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output logic signed [DATA_WIDTH:0]              first_o,
  output logic signed [DATA_WIDTH-1:0]            second_o
);

  localparam int unsigned W    = DATA_WIDTH + rpc_pkg::GUARD_BITS + 3;
  localparam int unsigned AW   = W - 1;
  localparam int unsigned LO   = rpc_pkg::GAIN_LO_BITS;
  localparam int unsigned KW   = rpc_pkg::GAIN_W;
  localparam int unsigned HI_W = AW - LO;
  localparam int unsigned SW   = HI_W + KW + 1;
  localparam int unsigned MW   = DATA_WIDTH + 3;
  localparam int unsigned NST  = 4;

  localparam logic [MW-1:0] MAX_MAG = MW'((64'd1 << DATA_WIDTH) - 64'd1);
  localparam logic [MW-1:0] MAX_XY  = MW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic [SW-1:0] RND     = SW'(1) << rpc_pkg::GAIN_RND_BIT;

  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;
  logic [NST-1:0] vin, ld;

  // sideband carried through stages 1 to 3
  rpc_pkg::cmd_e            cmd1_q, cmd2_q, cmd3_q;
  logic                     sx1_q, sy1_q, sx2_q, sy2_q, sx3_q, sy3_q;
  logic [DATA_WIDTH-1:0]    ang1_q, ang2_q, ang3_q;

  // stage 1: magnitudes and angle rounding
  logic [W-1:0]             nx, ny;
  logic [AW-1:0]            ax1_q, ay1_q;
  logic [rpc_pkg::ANG_W-1:0] acc;
  logic [DATA_WIDTH-1:0]    ang_rnd, ang_d;

  // stage 2: partial products
  logic [HI_W+KW-1:0]       hx2_q, hy2_q;
  logic [LO+KW-1:0]         plx, ply;
  logic [KW-1:0]            lx2_q, ly2_q;

  // stage 3: scaled magnitude
  logic [SW-1:0]            sumx, sumy;
  logic [MW-1:0]            mx3_q, my3_q;

  // stage 4: saturation
  logic [MW-1:0]            mcx, mcy, mmag;
  logic signed [DATA_WIDTH:0]   fx, first_d, first_q;
  logic signed [DATA_WIDTH-1:0] fy, second_d, second_q;

  assign rdy[NST] = ready_i;
  assign vin = {v_q[NST-2:0], valid_i};
  for (genvar k = 0; k < NST; k++) begin : g_hs
    assign rdy[k] = !v_q[k] || rdy[k+1];
    assign ld[k]  = rdy[k] && vin[k];
  end
  assign ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  assign acc = z_i[rpc_pkg::ANG_W-1:0];
  if (DATA_WIDTH >= rpc_pkg::ANG_W) begin : g_ang_full
    assign ang_rnd = acc;
  end else begin : g_ang_rnd
    logic [rpc_pkg::ANG_W-1:0] acc_r;
    assign acc_r   = acc + (rpc_pkg::ANG_W'(1) << (rpc_pkg::ANG_W - 1 - DATA_WIDTH));
    assign ang_rnd = acc_r[rpc_pkg::ANG_W-1 -: DATA_WIDTH];
  end

  always_comb begin
    nx    = -x_i;
    ny    = -y_i;
    ang_d = ctrl_i.zero ? '0 : ang_rnd;
  end

  assign plx  = (LO+KW)'(ax1_q[LO-1:0]) * (LO+KW)'(rpc_pkg::GAIN_K);
  assign ply  = (LO+KW)'(ay1_q[LO-1:0]) * (LO+KW)'(rpc_pkg::GAIN_K);
  assign sumx = SW'(hx2_q) + SW'(lx2_q) + RND;
  assign sumy = SW'(hy2_q) + SW'(ly2_q) + RND;

  always_comb begin
    mcx  = (mx3_q > MAX_XY) ? MAX_XY : mx3_q;
    mcy  = (my3_q > MAX_XY) ? MAX_XY : my3_q;
    mmag = (mx3_q > MAX_MAG) ? MAX_MAG : mx3_q;
    fx   = sx3_q ? -(DATA_WIDTH+1)'(mcx) : (DATA_WIDTH+1)'(mcx);
    fy   = sy3_q ? -DATA_WIDTH'(mcy) : DATA_WIDTH'(mcy);
    case (cmd3_q)
      rpc_pkg::CMD_TO_POLAR: begin
        first_d  = sx3_q ? '0 : (DATA_WIDTH+1)'(mmag);
        second_d = ang3_q;
      end
      rpc_pkg::CMD_TO_RECT: begin
        first_d  = fx;
        second_d = fy;
      end
      default: begin
        first_d  = '0;
        second_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      ax1_q  <= x_i[W-1] ? nx[AW-1:0] : x_i[AW-1:0];
      ay1_q  <= y_i[W-1] ? ny[AW-1:0] : y_i[AW-1:0];
      sx1_q  <= x_i[W-1];
      sy1_q  <= y_i[W-1];
      cmd1_q <= ctrl_i.cmd;
      ang1_q <= ang_d;
    end
    if (ld[1]) begin
      hx2_q  <= (HI_W+KW)'(ax1_q[AW-1:LO]) * (HI_W+KW)'(rpc_pkg::GAIN_K);
      hy2_q  <= (HI_W+KW)'(ay1_q[AW-1:LO]) * (HI_W+KW)'(rpc_pkg::GAIN_K);
      lx2_q  <= plx[LO+KW-1:LO];
      ly2_q  <= ply[LO+KW-1:LO];
      sx2_q  <= sx1_q;
      sy2_q  <= sy1_q;
      cmd2_q <= cmd1_q;
      ang2_q <= ang1_q;
    end
    if (ld[2]) begin
      mx3_q  <= sumx[SW-1:rpc_pkg::GAIN_SHIFT];
      my3_q  <= sumy[SW-1:rpc_pkg::GAIN_SHIFT];
      sx3_q  <= sx2_q;
      sy3_q  <= sy2_q;
      cmd3_q <= cmd2_q;
      ang3_q <= ang2_q;
    end
    if (ld[3]) begin
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  assign valid_o  = v_q[NST-1];
  assign first_o  = first_q;
  assign second_o = second_q;

endmodule

// ===== design/rect_polar_converter.sv =====
// rect_polar_converter: top level, a pipelined cordic that converts vectors
// between rectangular and polar form. Depends on rpc_pkg, rpc_prep,
// rpc_cordic_cell and rpc_post.

// Converts one 2-D vector per transaction. With tuser = 0 the operands are x
// and y and the result is the magnitude (low field) and the binary angle
// atan2(y, x), where 2^(DATA_WIDTH-1) stands for pi and +pi reads as -pi; a
// zero vector gives angle 0. With tuser = 1 the operands are a signed
// magnitude and a binary angle and the result is x and y, each saturated to
// +-(2^(DATA_WIDTH-1)-1). The datapath is a row of CORDIC_STAGES rotation
// cells behind one set-up register and ahead of a four-stage gain and
// saturation pipeline, so a new vector can enter every clock cycle while
// the output side does not stall. Every stage holds its own valid bit, so
// empty stages close up while the master side is stalled and input keeps
// flowing until the pipeline is full. There is no state between
// transactions and no configuration.
module rect_polar_converter #(
  parameter int unsigned DATA_WIDTH    = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // first_operand, second_operand, zero padding
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // cmd
  input  logic                              s_axis_tuser,
  // master side
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // first_result, second_result, zero padding
  output logic [((2*DATA_WIDTH+8)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned W       = DATA_WIDTH + rpc_pkg::GUARD_BITS + 3;
  localparam int unsigned OUT_W   = ((2 * DATA_WIDTH + 8) / 8) * 8;
  localparam int unsigned OUT_PAD = OUT_W - (2 * DATA_WIDTH + 1);

  // chain signals, index k feeds cell k
  logic                          ch_valid [CORDIC_STAGES+1];
  logic                          ch_ready [CORDIC_STAGES+1];
  rpc_pkg::ctrl_t                ch_ctrl  [CORDIC_STAGES+1];
  logic signed [W-1:0]           ch_x     [CORDIC_STAGES+1];
  logic signed [W-1:0]           ch_y     [CORDIC_STAGES+1];
  logic signed [rpc_pkg::ZW-1:0] ch_z     [CORDIC_STAGES+1];

  logic signed [DATA_WIDTH:0]    first_result;
  logic signed [DATA_WIDTH-1:0]  second_result;
  rpc_pkg::cmd_e                 cmd;

  assign cmd = rpc_pkg::cmd_e'(s_axis_tuser);

  // scaling and half-plane folding
  rpc_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .cmd_i   (cmd),
    .a_i     (s_axis_tdata[DATA_WIDTH-1:0]),
    .b_i     (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .valid_o (ch_valid[0]),
    .ready_i (ch_ready[0]),
    .ctrl_o  (ch_ctrl[0]),
    .x_o     (ch_x[0]),
    .y_o     (ch_y[0]),
    .z_o     (ch_z[0])
  );

  // one micro-rotation per cell, cell k shifts by k
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    rpc_cordic_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .STAGE      (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ch_valid[k]),
      .ready_o (ch_ready[k]),
      .ctrl_i  (ch_ctrl[k]),
      .x_i     (ch_x[k]),
      .y_i     (ch_y[k]),
      .z_i     (ch_z[k]),
      .valid_o (ch_valid[k+1]),
      .ready_i (ch_ready[k+1]),
      .ctrl_o  (ch_ctrl[k+1]),
      .x_o     (ch_x[k+1]),
      .y_o     (ch_y[k+1]),
      .z_o     (ch_z[k+1])
    );
  end

  // gain correction, rounding, saturation and the output register
  rpc_post #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (ch_valid[CORDIC_STAGES]),
    .ready_o  (ch_ready[CORDIC_STAGES]),
    .ctrl_i   (ch_ctrl[CORDIC_STAGES]),
    .x_i      (ch_x[CORDIC_STAGES]),
    .y_i      (ch_y[CORDIC_STAGES]),
    .z_i      (ch_z[CORDIC_STAGES]),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .first_o  (first_result),
    .second_o (second_result)
  );

  assign m_axis_tdata = {{OUT_PAD{1'b0}}, second_result, first_result};

endmodule

// ===== bench/tb_rect_polar_converter.sv =====
`timescale 1ns / 100ps
// tb_rect_polar_converter: self-checking bench for the rectangular/polar cordic
// converter, with a bit-exact predictor of both directions and random flow control.
// Depends on rpc_pkg and rect_polar_converter.
module tb_rect_polar_converter;

  localparam int unsigned DW           = 16;
  localparam int unsigned STAGES       = 16;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  localparam longint unsigned CORDIC_GAIN_Q30 = 64'd652032874;
  localparam logic [31:0]     PI_UNITS        = 32'h8000_0000;
  localparam longint          COORD_LIMIT     = 64'sd32767;
  localparam longint          MAG_LIMIT       = 64'sd65535;

  // atan(2^-i), full circle = 2^32
  localparam logic [31:0] ATAN_STEP [0:STAGES-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct packed {
    logic [DW:0]   first;   // magnitude or x
    logic [DW-1:0] second;  // angle or y
  } result_t;

  typedef struct packed {
    rpc_pkg::cmd_e cmd;
    logic [DW-1:0] op1;
    logic [DW-1:0] op2;
    logic          typed;   // expected result given in the row itself
    result_t       res;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 24;

  // directed vectors: axes, corners, both half planes and every quadrant boundary
  localparam stim_row_t DIRECTED_TBL [0:DIRECTED_ROWS-1] = '{
    '{rpc_pkg::CMD_TO_POLAR, 16'h0000, 16'h0000, 1'b1, '{17'd0, 16'd0}},  // zero vector
    '{rpc_pkg::CMD_TO_POLAR, 16'h7FFF, 16'h0000, 1'b0, '0},
    '{rpc_pkg::CMD_TO_POLAR, 16'h8000, 16'h0000, 1'b0, '0},  // left half plane on the axis
    '{rpc_pkg::CMD_TO_POLAR, 16'hFFFF, 16'h0000, 1'b0, '0},
    '{rpc_pkg::CMD_TO_POLAR, 16'h0001, 16'h0000, 1'b0, '0},
    '{rpc_pkg::CMD_TO_POLAR, 16'h0000, 16'h7FFF, 1'b0, '0},
    '{rpc_pkg::CMD_TO_POLAR, 16'h0000, 16'h8000, 1'b0, '0},
    '{rpc_pkg::CMD_TO_POLAR, 16'h7FFF, 16'h7FFF, 1'b0, '0},  // largest magnitude in the first quadrant
    '{rpc_pkg::CMD_TO_POLAR, 16'h8000, 16'h8000, 1'b0, '0},
    '{rpc_pkg::CMD_TO_POLAR, 16'h8000, 16'h7FFF, 1'b0, '0},
    '{rpc_pkg::CMD_TO_POLAR, 16'h7FFF, 16'h8000, 1'b0, '0},
    '{rpc_pkg::CMD_TO_POLAR, 16'h0001, 16'hFFFF, 1'b0, '0},
    '{rpc_pkg::CMD_TO_POLAR, 16'hFFFF, 16'h0001, 1'b0, '0},
    '{rpc_pkg::CMD_TO_RECT,  16'h0000, 16'h4000, 1'b1, '{17'd0, 16'd0}},  // zero magnitude
    '{rpc_pkg::CMD_TO_RECT,  16'h0000, 16'h8000, 1'b1, '{17'd0, 16'd0}},
    '{rpc_pkg::CMD_TO_RECT,  16'h7FFF, 16'h0000, 1'b0, '0},
    '{rpc_pkg::CMD_TO_RECT,  16'h7FFF, 16'h4000, 1'b0, '0},  // quarter turn, folded
    '{rpc_pkg::CMD_TO_RECT,  16'h7FFF, 16'h3FFF, 1'b0, '0},
    '{rpc_pkg::CMD_TO_RECT,  16'h7FFF, 16'h8000, 1'b0, '0},
    '{rpc_pkg::CMD_TO_RECT,  16'h7FFF, 16'hBFFF, 1'b0, '0},
    '{rpc_pkg::CMD_TO_RECT,  16'h7FFF, 16'hC000, 1'b0, '0},
    '{rpc_pkg::CMD_TO_RECT,  16'h8000, 16'h0000, 1'b0, '0},  // negative magnitude, saturates
    '{rpc_pkg::CMD_TO_RECT,  16'h8000, 16'h2000, 1'b0, '0},
    '{rpc_pkg::CMD_TO_RECT,  16'h7FFF, 16'h7FFF, 1'b0, '0}
  };

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_valid = 1'b0;
  logic [31:0]   s_data = '0;
  rpc_pkg::cmd_e s_user = rpc_pkg::CMD_TO_POLAR;
  logic          s_axis_tready;
  logic          m_axis_tvalid;
  logic          m_ready = 1'b0;
  logic [39:0]   m_axis_tdata;

  result_t       next_expect = '0;  // travels with the vector being offered
  result_t       pending_results [$];
  int unsigned   mismatch_count = 0;
  int unsigned   result_index = 0;
  int unsigned   quiet_cycles = 0;
  bit            steady = 1'b0;     // long stretch without any idling

  // clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rect_polar_converter #(
    .DATA_WIDTH    (DW),
    .CORDIC_STAGES (STAGES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // multiply by the converged gain and drop the guard and q30 bits, rounding
  // half away from zero
  function automatic longint apply_gain(longint v);
    longint unsigned m;
    longint unsigned r;
    m = (v < 0) ? longint'(-v) : longint'(v);
    r = ((m >> 20) * CORDIC_GAIN_Q30 + (((m & 64'hF_FFFF) * CORDIC_GAIN_Q30) >> 20)
         + (64'd1 << 25)) >> 26;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic result_t predict_conversion(rpc_pkg::cmd_e cmd,
                                                 logic signed [DW-1:0] op1,
                                                 logic signed [DW-1:0] op2);
    longint          x;
    longint          y;
    longint          dx;
    longint          dy;
    longint          resid;
    longint          first;
    longint          second;
    longint unsigned rounded;
    logic [31:0]     acc;
    logic [31:0]     z;
    result_t         r;
    x = longint'(op1) * (64'sd1 <<< FRAC_BITS);
    if (cmd == rpc_pkg::CMD_TO_POLAR) begin
      if (op1 == 0 && op2 == 0) begin
        // zero vector: angle forced to 0
        first = 0;
        second = 0;
      end else begin
        y = longint'(op2) * (64'sd1 <<< FRAC_BITS);
        acc = '0;
        if (x < 0) begin
          // left half plane: mirror through the origin and start at pi
          x = -x;
          y = -y;
          acc = PI_UNITS;
        end
        for (int i = 0; i < STAGES; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            acc = acc + ATAN_STEP[i];
          end else begin
            x = x - dx;
            y = y + dy;
            acc = acc - ATAN_STEP[i];
          end
        end
        first = clamp_range(apply_gain(x), 0, MAG_LIMIT);
        rounded = (longint'({32'd0, acc}) + (64'd1 << (31 - DW))) >> (32 - DW);
        second = longint'(rounded & 64'hFFFF);
      end
    end else begin
      y = 0;
      z = {op2, {(32 - DW){1'b0}}};
      if (z[31:30] == 2'b01 || z[31:30] == 2'b10) begin
        // beyond a quarter turn: start from the opposite point
        x = -x;
        z = z - PI_UNITS;
      end
      resid = longint'(signed'(z));
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (resid >= 0) begin
          x = x - dx;
          y = y + dy;
          resid = resid - longint'(ATAN_STEP[i]);
        end else begin
          x = x + dx;
          y = y - dy;
          resid = resid + longint'(ATAN_STEP[i]);
        end
      end
      first = clamp_range(apply_gain(x), -COORD_LIMIT, COORD_LIMIT);
      second = clamp_range(apply_gain(y), -COORD_LIMIT, COORD_LIMIT);
    end
    r.first = first[DW:0];
    r.second = second[DW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
    $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
             result_index, field, want, got);
    mismatch_count++;
  endtask

  // offer one vector, starting and ending at a falling edge
  task automatic send_vector(rpc_pkg::cmd_e cmd, logic [DW-1:0] op1, logic [DW-1:0] op2,
                             result_t expect_res);
    while (!steady && $urandom_range(99) < 34) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid     <= 1'b1;
    s_user      <= cmd;
    s_data      <= {op2, op1};
    next_expect <= expect_res;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // master side back-pressure, changed on the falling edge
  always @(negedge clk_i) begin
    m_ready <= steady || ($urandom_range(99) >= 34);
  end

  // scoreboard and watchdog, sampled on the rising edge
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (s_valid && s_axis_tready)
        pending_results.push_back(next_expect);
      if (m_axis_tvalid && m_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transaction", 0, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[DW:0] !== want.first)
            report_mismatch("first_result", want.first, m_axis_tdata[DW:0]);
          if (m_axis_tdata[2*DW:DW+1] !== want.second)
            report_mismatch("second_result", want.second, m_axis_tdata[2*DW:DW+1]);
          if (m_axis_tdata[39:2*DW+1] !== '0)
            report_mismatch("padding", 0, m_axis_tdata[39:2*DW+1]);
        end
        result_index++;
      end
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t     row;
    result_t       exp_res;
    rpc_pkg::cmd_e cmd;
    logic [DW-1:0] op1;
    logic [DW-1:0] op2;
    logic [DW-1:0] corner [0:4];
    int unsigned   kind;
    corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};

    // single reset at the start of the run
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_TBL[i]) begin
      row = DIRECTED_TBL[i];
      exp_res = row.typed ? row.res : predict_conversion(row.cmd, row.op1, row.op2);
      send_vector(row.cmd, row.op1, row.op2, exp_res);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 400 && n < 650);
      cmd = rpc_pkg::cmd_e'($urandom_range(1));
      kind = $urandom_range(99);
      if (kind < 40) begin
        op1 = DW'($urandom());
        op2 = DW'($urandom());
      end else if (kind < 55) begin
        // tiny vectors, where the guard bits matter most
        op1 = DW'($urandom_range(16) - 8);
        op2 = DW'($urandom_range(16) - 8);
      end else if (kind < 75) begin
        // around multiples of an eighth turn: quadrant folds and diagonals
        op1 = DW'($urandom());
        op2 = DW'(($urandom_range(7) << 13) + $urandom_range(4) - 2);
      end else if (kind < 85) begin
        op1 = corner[$urandom_range(4)];
        op2 = corner[$urandom_range(4)];
      end else begin
        // one component zero
        op1 = DW'($urandom());
        op2 = '0;
        if ($urandom_range(1)) begin
          op2 = op1;
          op1 = '0;
        end
      end
      send_vector(cmd, op1, op2, predict_conversion(cmd, op1, op2));
    end
    steady = 1'b0;
    s_valid <= 1'b0;

    // drain: the watchdog covers a result that never arrives
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rpc_pkg.sv
design/rpc_prep.sv
design/rpc_cordic_cell.sv
design/rpc_post.sv
design/rect_polar_converter.sv
bench/tb_rect_polar_converter.sv
